// File: src/dmts_pkg.sv
// Shared constants and types for the de-duplicating move-to-top stack.
`timescale 1ns / 1ps

package dmts_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int ITEM_BITS_DEFAULT = 8;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_t;

endpackage

// File: src/dmts_if.sv
// Request and response channel interfaces of the stack.
`timescale 1ns / 1ps

interface dmts_req_if #(
  parameter int ITEM_BITS = dmts_pkg::ITEM_BITS_DEFAULT
) ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ITEM_BITS-1:0] push_value;

  modport source (output valid, mode, push_value, input ready);
  modport sink   (input valid, mode, push_value, output ready);
endinterface

interface dmts_rsp_if #(
  parameter int ITEM_BITS  = dmts_pkg::ITEM_BITS_DEFAULT,
  parameter int COUNT_BITS = $clog2(dmts_pkg::DEPTH_DEFAULT + 1)
) ();
  logic                  valid;
  logic                  ready;
  logic [ITEM_BITS-1:0]  popped_value;
  logic [1:0]            status;
  logic                  was_duplicate;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  is_empty;

  modport source (output valid, popped_value, status, was_duplicate, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, popped_value, status, was_duplicate, entry_count, is_empty,
                  output ready);
endinterface

// File: src/dmts_ctrl.sv
// Handshake controller: decides when a transaction executes and when a result is held.
`timescale 1ns / 1ps

module dmts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic exec
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // a held result leaving this cycle frees the output register
  assign in_ready  = (state == ST_IDLE) || out_ready;
  assign out_valid = (state == ST_HOLD);
  assign exec      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (exec) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (exec) state_next = ST_HOLD;
        else if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a result still waiting is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !exec)
    else $error("result overwritten before it was taken");

  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    exec |=> out_valid)
    else $error("executed transaction produced no result");

endmodule

// File: src/dmts_datapath.sv
// Stack cells, parallel compare, shift-on-move and the result register.
`timescale 1ns / 1ps

module dmts_datapath #(
  parameter int DEPTH      = dmts_pkg::DEPTH_DEFAULT,
  parameter int ITEM_BITS  = dmts_pkg::ITEM_BITS_DEFAULT,
  parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  exec,
  input  logic                  mode,
  input  logic [ITEM_BITS-1:0]  push_value,
  output logic [ITEM_BITS-1:0]  popped_value,
  output logic [1:0]            status,
  output logic                  was_duplicate,
  output logic [COUNT_BITS-1:0] entry_count,
  output logic                  is_empty
);

  // cell 0 is the top of the stack, cell count-1 the bottom
  logic [ITEM_BITS-1:0]  entries [DEPTH];
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] hit_below;   // a match at this cell or deeper
  logic             found;
  logic             full;
  logic             is_pop;
  logic             do_pop;
  logic             load_top;
  logic [DEPTH-1:0] shift_up;

  dmts_pkg::status_t    status_next;
  dmts_pkg::status_t    status_q;
  logic [ITEM_BITS-1:0] popped_next;

  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (COUNT_BITS'(i) < count) && (entries[i] == push_value);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      acc          = acc | match[i];
      hit_below[i] = acc;
    end
  end

  assign found  = |match;
  assign full   = (count == COUNT_BITS'(DEPTH));
  assign is_pop = (mode == dmts_pkg::MODE_POP);

  always_comb begin
    do_pop      = 1'b0;
    load_top    = 1'b0;
    shift_up    = '0;
    count_next  = count;
    status_next = dmts_pkg::STATUS_OK;
    popped_next = '0;
    if (is_pop) begin
      if (count == '0) begin
        status_next = dmts_pkg::STATUS_POP_EMPTY;
      end else begin
        do_pop      = exec;
        popped_next = entries[0];
        count_next  = count - COUNT_BITS'(1);
      end
    end else if (found) begin
      // cells above the hit slide down one place, the hit value lands on top
      load_top = exec;
      shift_up = exec ? hit_below : '0;
    end else if (full) begin
      status_next = dmts_pkg::STATUS_PUSH_FULL;
    end else begin
      load_top   = exec;
      shift_up   = exec ? '1 : '0;
      count_next = count + COUNT_BITS'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (g == 0 && load_top) begin
        entries[g] <= push_value;
      end else if (do_pop && g < DEPTH - 1) begin
        entries[g] <= entries[(g + 1) % DEPTH];
      end else if (shift_up[g] && g > 0) begin
        entries[g] <= entries[(g + DEPTH - 1) % DEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      popped_value  <= popped_next;
      status_q      <= status_next;
      was_duplicate <= !is_pop && found;
      entry_count   <= count_next;
      is_empty      <= (count_next == '0);
    end
  end

  assign status = status_q;

  // no value is ever stored twice
  a_no_dup: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("duplicate value in stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("stack count beyond depth");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    load_top |=> entries[0] == $past(push_value))
    else $error("pushed value not on top");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> count == $past(count) - COUNT_BITS'(1))
    else $error("pop did not shrink stack");

endmodule

// File: src/dedup_move_to_top_stack_top.sv
// Top level of the de-duplicating move-to-top stack.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        mode, push_value
//   rsp      out  valid/ready        popped_value, status, was_duplicate,
//                                    entry_count, is_empty
//
// One transaction per cycle while the response is not stalled: compare against
// every cell and the shift-on-move of the cell row complete in the cycle a
// request is taken; the result appears in the output register in the next cycle.
// A new request is taken in the same cycle a held result is taken.
// Synchronous reset empties the stack; cell contents are not cleared.
// A stalled response holds its result and blocks requests until taken.
`timescale 1ns / 1ps

module dedup_move_to_top_stack_top #(
  parameter int DEPTH     = dmts_pkg::DEPTH_DEFAULT,
  parameter int ITEM_BITS = dmts_pkg::ITEM_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  dmts_req_if.sink  req,
  dmts_rsp_if.source rsp
);

  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic exec;

  dmts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .exec      (exec)
  );

  dmts_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_BITS  (ITEM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .exec          (exec),
    .mode          (req.mode),
    .push_value    (req.push_value),
    .popped_value  (rsp.popped_value),
    .status        (rsp.status),
    .was_duplicate (rsp.was_duplicate),
    .entry_count   (rsp.entry_count),
    .is_empty      (rsp.is_empty)
  );

endmodule
